// File: hw/rtl/positional_list_engine_core_defines.svh
// Assertion macros shared by the positional list engine RTL.
// Needs nothing else; included by positional_list_engine_core.sv, which carries assertions.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// Checked property, switched off while the reset is asserted.
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds across reset.
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
// Depends on nothing; used by the interfaces, the cell and the top level.
package ple_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Broadcast to every cell of the chain for one accepted command.
    typedef struct packed {
        logic                    append;
        logic                    shift_up;
        logic                    shift_down;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

// File: hw/rtl/ple_cmd_if.sv
// Command channel of the positional list engine: valid, ready and one command word.
// Depends on ple_pkg.
interface ple_cmd_if;
    import ple_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, cmd, position, value, input ready);
    modport sink   (input valid, cmd, position, value, output ready);
endinterface

// File: hw/rtl/ple_res_if.sv
// Result channel of the positional list engine: valid, ready and one result word.
// Depends on ple_pkg.
interface ple_res_if;
    import ple_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]      count;

    modport source (output valid, status, read_value, count, input ready);
    modport sink   (input valid, status, read_value, count, output ready);
endinterface

// File: hw/rtl/ple_cell.sv
// One storage cell of the list chain: holds one element and takes a new value,
// the command's, its lower neighbour's or its upper neighbour's. Depends on ple_pkg.
module ple_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                            i_clk,
    input  ple_pkg::t_cell_ctrl             i_ctrl,
    input  logic [CNT_W-1:0]                i_count,
    input  logic signed [ple_pkg::VAL_W-1:0] i_prev,
    input  logic signed [ple_pkg::VAL_W-1:0] i_next,
    output logic signed [ple_pkg::VAL_W-1:0] o_data
);
    import ple_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [CMP_W-1:0]        w_pos;
    logic [CMP_W-1:0]        w_cnt;
    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] n_data;

    assign w_pos = CMP_W'(i_ctrl.pos);
    assign w_cnt = CMP_W'(i_count);

    always_comb begin
        n_data = r_data;
        priority if ((i_ctrl.append && MY_IDX == w_cnt) ||
                     (i_ctrl.shift_up && MY_IDX == w_pos)) begin
            n_data = i_ctrl.value;
        end else if (i_ctrl.shift_up && MY_IDX > w_pos) begin
            n_data = i_prev;
        end else if (i_ctrl.shift_down && MY_IDX >= w_pos) begin
            n_data = i_next;
        end else begin
            // No command touches this cell, so it keeps its element.
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

// File: hw/rtl/positional_list_engine_core.sv
// Top level of the positional list engine: command decode, element count,
// the chain of ple_cell storage cells and the result register.
// Depends on ple_pkg, ple_cmd_if, ple_res_if, ple_cell and the defines header.

// The engine keeps an ordered list of up to CAPACITY signed 32-bit elements in a
// row of cells, each holding one element. A command is one of:
// append, insert at a position, remove the last element, erase at a position or
// read at a position. Insert and erase move every affected element one cell up or
// down in the same clock edge, each cell loading from its neighbour, so every
// command completes at that edge and its result word appears on the result channel
// on the following cycle. One command per cycle is sustained for as long as the
// result channel takes each word; the single result register is what sets that
// figure, and the command channel stalls only while a result waits untaken. A read
// selects among the first sixteen cells, the reach of the four-bit position.
// Cells are not cleared at reset; only the count and the valid flag of the result
// are, and no element beyond the count is ever returned. A full list reports a full
// status rather than growing; insert and erase demand a position below the count.
module positional_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input logic     i_clk,
    input logic     i_rst_n,
    ple_cmd_if.sink   i_cmd,
    ple_res_if.source o_res
);
    import ple_pkg::*;
    `include "positional_list_engine_core_defines.svh"

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int RD_N   = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // Element count and the handshake of the command channel.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_pos_ok;
    logic             w_full;
    logic             w_empty;

    // Result register.
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status;
    logic signed [VAL_W-1:0] r_read_value;
    logic [COUNT_W-1:0]      r_out_count;
    logic [STATUS_W-1:0]     n_status;
    logic signed [VAL_W-1:0] n_read_value;
    logic [EXT_W-1:0]        w_count_ext;

    t_cell_ctrl              w_ctrl;
    logic signed [VAL_W-1:0] w_cell_data [CAPACITY];
    logic signed [VAL_W-1:0] w_sel_data;

    // A new command is taken whenever the result register is free or drains now.
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_pos_ok = CMP_W'(i_cmd.position) < CMP_W'(r_count);
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);

    // Read selection over the cells that a position can reach.
    always_comb begin
        w_sel_data = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (i_cmd.position == POS_W'(i)) begin
                w_sel_data = w_cell_data[i];
            end
        end
    end

    // Command decode: status, read data, new count and the cell controls.
    always_comb begin
        n_status          = ST_OK;
        n_read_value      = '0;
        n_count           = r_count;
        w_ctrl.append     = 1'b0;
        w_ctrl.shift_up   = 1'b0;
        w_ctrl.shift_down = 1'b0;
        w_ctrl.pos        = i_cmd.position;
        w_ctrl.value      = i_cmd.value;
        unique case (i_cmd.cmd)
            CMD_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.append = w_accept;
                    n_count       = r_count + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (!w_pos_ok) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.shift_up = w_accept;
                    n_count         = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            CMD_ERASE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_pos_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctrl.shift_down = w_accept;
                    n_count           = r_count - 1'b1;
                end
            end
            CMD_READ: begin
                if (!w_pos_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_read_value = w_sel_data;
                end
            end
            default: begin
            end
        endcase
    end

    // Cell chain; the top cell feeds itself, the bottom one takes the command value.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_prev;
        logic signed [VAL_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_cmd.value;
        end else begin : g_mid_lo
            assign w_prev = w_cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_cell_data[g];
        end else begin : g_mid_hi
            assign w_next = w_cell_data[g+1];
        end

        ple_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_count (r_count),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_data  (w_cell_data[g])
        );
    end

    assign w_count_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
            r_out_count  <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.read_value = r_read_value;
    assign o_res.count      = r_out_count;

    // The count starts empty after reset and never passes the capacity.
    `PLE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (r_count == '0), "count not cleared")
    `PLE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "count above capacity")
    // An append to a list with room grows it by exactly one element.
    `PLE_ASSERT(a_append_grows, i_clk, i_rst_n, (w_accept && i_cmd.cmd == CMD_APPEND && !w_full) |=> (r_count == $past(r_count) + 1'b1), "append did not grow list")
    // Every accepted command leaves a result word waiting on the next cycle.
    `PLE_ASSERT(a_result_follows, i_clk, i_rst_n, w_accept |=> o_res.valid, "result word missing")
endmodule
